>>> hdl/pgm_pkg.sv
// shared constants, types and register codes for the pyramid gradient block
// no dependencies; used by every other file of the block but pgm_ram
package pgm_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int NUM_LEVELS  = 4;
   localparam int LEVEL_MAX   = 3;
   localparam int PIX_W       = 8;
   localparam int DIM_W       = 11;
   localparam int COL_W       = 10;
   localparam int ROW_W       = 11;
   localparam int LVL_W       = 2;
   localparam int VAL_W       = 14;
   localparam int GRAD_W      = 16;
   localparam int SQ_W        = 31;
   localparam int CSR_IDX_W   = 2;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_CNT_W  = 3;

   localparam int L0_DEPTH = 2 * MAX_WIDTH;
   localparam int L1_DEPTH = 2 * (MAX_WIDTH >> 1);
   localparam int L2_DEPTH = 2 * (MAX_WIDTH >> 2);
   localparam int L3_DEPTH = 2 * (MAX_WIDTH >> 3);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_OUTPUT_LEVEL = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [LVL_W-1:0] level;
   } cfg_type;

   typedef struct packed {
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic [SQ_W-1:0]          grad_squared;
      logic                     last_in_frame;
   } result_type;

endpackage

>>> hdl/pgm_if.sv
// channel interfaces of the pyramid gradient block: pixel, result and register write
// depends on pgm_pkg for field widths
interface pgm_req_if;
   logic                        valid;
   logic                        ready;
   logic [pgm_pkg::PIX_W-1:0]   pixel;
   logic                        frame_start;
   modport source (output valid, pixel, frame_start, input ready);
   modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface pgm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pgm_pkg::GRAD_W-1:0]  grad_x;
   logic signed [pgm_pkg::GRAD_W-1:0]  grad_y;
   logic [pgm_pkg::SQ_W-1:0]           grad_squared;
   logic                               last_in_frame;
   modport source (output valid, grad_x, grad_y, grad_squared, last_in_frame, input ready);
   modport sink (input valid, grad_x, grad_y, grad_squared, last_in_frame, output ready);
endinterface

interface pgm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pgm_pkg::CSR_IDX_W-1:0]   index;
   logic [pgm_pkg::DIM_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/pgm_ram.sv
// generic single-write, dual-read ram with registered read data
// no dependencies
module pgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

>>> hdl/pgm_csr.sv
// configuration registers and their clamped working values
// depends on pgm_pkg and pgm_csr_if
module pgm_csr (
   input  logic              clock,
   input  logic              reset,
   pgm_csr_if.sink           csr_chan,
   output pgm_pkg::cfg_type  cfg
);
   import pgm_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             wr;

   assign csr_chan.ready = 1'b1;
   assign wr = csr_chan.valid && csr_chan.ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      level_in  = level_ff;
      if (wr) begin
         unique case (csr_chan.index)
            CSR_IMAGE_WIDTH:  width_in  = csr_chan.data;
            CSR_IMAGE_HEIGHT: height_in = csr_chan.data;
            CSR_OUTPUT_LEVEL: level_in  = csr_chan.data[LVL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         level_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         level_ff  <= level_in;
      end
   end

   // zero size counts as one, width saturates at the line buffer size
   always_comb begin
      if (width_ff > DIM_W'(MAX_WIDTH)) cfg.width = DIM_W'(MAX_WIDTH);
      else if (width_ff == '0)          cfg.width = DIM_W'(1);
      else                              cfg.width = width_ff;
      cfg.height = (height_ff == '0) ? DIM_W'(1) : height_ff;
      cfg.level  = (level_ff > LVL_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX) : level_ff;
   end
endmodule

>>> hdl/pgm_out_fifo.sv
// four-entry result queue between the datapath and the result channel
// depends on pgm_pkg
module pgm_out_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  pgm_pkg::result_type          push_data,
   input  logic                         pop,
   output logic                         out_valid,
   output pgm_pkg::result_type          out_data,
   output logic [pgm_pkg::FIFO_CNT_W-1:0] count
);
   import pgm_pkg::*;

   result_type            entry_ff [FIFO_DEPTH];
   logic [1:0]            wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      end
   end
endmodule

>>> hdl/pyramid_gradient_magnitude_top.sv
// top level of the pyramid gradient block: position tracking, pyramid build, gradients
// depends on pgm_pkg, pgm_if, pgm_ram, pgm_csr and pgm_out_fifo

// Grey pixels enter in raster order, one transaction per clock; a 2x2 sum
// pyramid of four levels is built in line buffers (one dual-read ram per level,
// two rows each), and for the selected level every pixel of rows 1 to h-2
// yields one result transaction with dx, dy and dx^2+dy^2. A pixel is taken
// every cycle as long as the result side keeps up; a result passes stage 1,
// stage 2 and the queue after the pixel that completes the level pixel below
// it. The rate is set by the level rams: each serves two reads at accept and
// one write in the next cycle. No clearing pass after reset: line buffers are
// only read at entries written earlier in the same frame. frame_start
// restarts the raster position at row 0, column 0. The four-entry result
// queue takes up to three results in flight while the result side stalls.
module pyramid_gradient_magnitude_top (
   input  logic      clock,
   input  logic      reset,
   pgm_req_if.sink   req_chan,
   pgm_rsp_if.source rsp_chan,
   pgm_csr_if.sink   csr_chan
);
   import pgm_pkg::*;

   cfg_type cfg;
   logic    accept;

   // raster position
   logic [COL_W-1:0] pos_col_ff, pos_col_in;
   logic [ROW_W-1:0] pos_row_ff, pos_row_in;
   logic [COL_W:0]   c_base, c_next;
   logic [COL_W-1:0] c_cur;
   logic [ROW_W-1:0] r_cur, r_next;
   logic [3:0]       ev;

   // ram ports
   logic [10:0] a0_rd, b0_rd, a0_wr;
   logic [9:0]  a1_rd, b1_rd, a1_wr;
   logic [8:0]  a2_rd, b2_rd, a2_wr;
   logic [7:0]  a3_rd, b3_rd, a3_wr;
   logic [9:0]  x0_inc;
   logic [8:0]  x1_inc;
   logic [7:0]  x2_inc;
   logic [6:0]  x3_inc;
   logic [7:0]  rd0a, rd0b;
   logic [9:0]  rd1a, rd1b;
   logic [11:0] rd2a, rd2b;
   logic [13:0] rd3a, rd3b;

   // stage 1
   logic             s1_valid_ff;
   logic [3:0]       s1_ev_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [7:0]       val0, prev0_ff;
   logic [9:0]       val1, prev1_ff;
   logic [11:0]      val2, prev2_ff;
   logic [13:0]      val3;
   logic [3:0]       wr_en;

   logic [VAL_W-1:0] g_val, g_up, g_rt;
   logic [COL_W-1:0] x_l;
   logic [ROW_W-1:0] y_l;
   logic [DIM_W-1:0] w_l, h_l;
   logic             ev_l, x_is0, x_is1, x_last, has_right, grad_ev, last;
   logic [VAL_W-1:0] left, right;
   logic [VAL_W-1:0] cur_first_ff, first1_ff, lastcur_ff, last1_ff, hist1_ff, hist2_ff;
   logic [2:0]       shamt;
   logic signed [GRAD_W-1:0] dx, dy, gx, gy;

   // stage 2
   logic                     s2_valid_ff;
   logic signed [GRAD_W-1:0] s2_gx_ff, s2_gy_ff;
   logic                     s2_last_ff;
   logic signed [31:0]       sqx, sqy;
   logic [31:0]              sq_sum;
   result_type               push_data, out_data;
   logic                     out_valid, pop;
   logic [FIFO_CNT_W-1:0]    fifo_count;

   pgm_csr u_csr (.clock(clock), .reset(reset), .csr_chan(csr_chan), .cfg(cfg));

   // ready looks at everything that may still land in the queue
   assign req_chan.ready = (4'(fifo_count) + 4'(s1_valid_ff) + 4'(s2_valid_ff))
                           < 4'(FIFO_DEPTH);
   assign accept = req_chan.valid && req_chan.ready;

   // position of the incoming pixel and the one after it
   always_comb begin
      c_base = req_chan.frame_start ? '0 : {1'b0, pos_col_ff};
      r_cur  = req_chan.frame_start ? '0 : pos_row_ff;
      if (c_base >= cfg.width) begin
         c_base = '0;
         r_cur  = r_cur + 1'b1;
      end
      if (r_cur >= cfg.height) r_cur = '0;
      c_cur  = c_base[COL_W-1:0];
      c_next = c_base + 1'b1;
      r_next = r_cur;
      if (c_next >= cfg.width) begin
         c_next = '0;
         r_next = r_cur + 1'b1;
         if (r_next >= cfg.height) r_next = '0;
      end
      pos_col_in = accept ? c_next[COL_W-1:0] : pos_col_ff;
      pos_row_in = accept ? r_next : pos_row_ff;
   end

   // which levels complete a pixel with this transaction
   always_comb begin
      ev[0] = 1'b1;
      ev[1] = ev[0] && (cfg.level >= 2'd1) && r_cur[0] && c_cur[0]
              && ((r_cur >> 1) < (cfg.height >> 1))
              && (({1'b0, c_cur} >> 1) < (cfg.width >> 1));
      ev[2] = ev[1] && (cfg.level >= 2'd2) && r_cur[1] && c_cur[1]
              && ((r_cur >> 2) < (cfg.height >> 2))
              && (({1'b0, c_cur} >> 2) < (cfg.width >> 2));
      ev[3] = ev[2] && (cfg.level >= 2'd3) && r_cur[2] && c_cur[2]
              && ((r_cur >> 3) < (cfg.height >> 3))
              && (({1'b0, c_cur} >> 3) < (cfg.width >> 3));
   end

   // read addresses: the selected level reads the row two above and the
   // next column of the row above, lower levels read the even row pair
   assign x0_inc = c_cur + 10'd1;
   assign x1_inc = c_cur[9:1] + 9'd1;
   assign x2_inc = c_cur[9:2] + 8'd1;
   assign x3_inc = c_cur[9:3] + 7'd1;

   always_comb begin
      if (cfg.level == 2'd0) begin
         a0_rd = {r_cur[0], c_cur};
         b0_rd = {~r_cur[0], x0_inc};
      end else begin
         a0_rd = {1'b0, c_cur[9:1], 1'b0};
         b0_rd = {1'b0, c_cur};
      end
      if (cfg.level == 2'd1) begin
         a1_rd = {r_cur[1], c_cur[9:1]};
         b1_rd = {~r_cur[1], x1_inc};
      end else begin
         a1_rd = {1'b0, c_cur[9:2], 1'b0};
         b1_rd = {1'b0, c_cur[9:1]};
      end
      if (cfg.level == 2'd2) begin
         a2_rd = {r_cur[2], c_cur[9:2]};
         b2_rd = {~r_cur[2], x2_inc};
      end else begin
         a2_rd = {1'b0, c_cur[9:3], 1'b0};
         b2_rd = {1'b0, c_cur[9:2]};
      end
      a3_rd = {r_cur[3], c_cur[9:3]};
      b3_rd = {~r_cur[3], x3_inc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_col_ff  <= '0;
         pos_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         pos_col_ff  <= pos_col_in;
         pos_row_ff  <= pos_row_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= grad_ev;
      end
      s1_ev_ff    <= ev;
      s1_col_ff   <= c_cur;
      s1_row_ff   <= r_cur;
      s1_pixel_ff <= req_chan.pixel;
   end

   // stage 1: 2x2 sums, each level adds its even row pair, the left
   // neighbour of this row and the value just finished below
   assign val0 = s1_pixel_ff;
   assign val1 = 10'(rd0a) + 10'(rd0b) + 10'(prev0_ff) + 10'(val0);
   assign val2 = 12'(rd1a) + 12'(rd1b) + 12'(prev1_ff) + 12'(val1);
   assign val3 = 14'(rd2a) + 14'(rd2b) + 14'(prev2_ff) + 14'(val2);

   assign wr_en = s1_valid_ff ? s1_ev_ff : 4'b0000;
   assign a0_wr = {s1_row_ff[0], s1_col_ff};
   assign a1_wr = {s1_row_ff[1], s1_col_ff[9:1]};
   assign a2_wr = {s1_row_ff[2], s1_col_ff[9:2]};
   assign a3_wr = {s1_row_ff[3], s1_col_ff[9:3]};

   pgm_ram #(.WIDTH(8), .DEPTH(L0_DEPTH)) u_level0_ram (
      .clock(clock), .wr_en(wr_en[0]), .wr_addr(a0_wr), .wr_data(val0),
      .rd_addr_a(a0_rd), .rd_data_a(rd0a), .rd_addr_b(b0_rd), .rd_data_b(rd0b));
   pgm_ram #(.WIDTH(10), .DEPTH(L1_DEPTH)) u_level1_ram (
      .clock(clock), .wr_en(wr_en[1]), .wr_addr(a1_wr), .wr_data(val1),
      .rd_addr_a(a1_rd), .rd_data_a(rd1a), .rd_addr_b(b1_rd), .rd_data_b(rd1b));
   pgm_ram #(.WIDTH(12), .DEPTH(L2_DEPTH)) u_level2_ram (
      .clock(clock), .wr_en(wr_en[2]), .wr_addr(a2_wr), .wr_data(val2),
      .rd_addr_a(a2_rd), .rd_data_a(rd2a), .rd_addr_b(b2_rd), .rd_data_b(rd2b));
   pgm_ram #(.WIDTH(14), .DEPTH(L3_DEPTH)) u_level3_ram (
      .clock(clock), .wr_en(wr_en[3]), .wr_addr(a3_wr), .wr_data(val3),
      .rd_addr_a(a3_rd), .rd_data_a(rd3a), .rd_addr_b(b3_rd), .rd_data_b(rd3b));

   // selected level, widened to the level-3 value width
   always_comb begin
      unique case (cfg.level)
         2'd0: begin
            g_val = VAL_W'(val0); g_up = VAL_W'(rd0a); g_rt = VAL_W'(rd0b);
            x_l = s1_col_ff;
            y_l = s1_row_ff;
            w_l = cfg.width;
            h_l = cfg.height;
         end
         2'd1: begin
            g_val = VAL_W'(val1); g_up = VAL_W'(rd1a); g_rt = VAL_W'(rd1b);
            x_l = COL_W'(s1_col_ff[9:1]);
            y_l = ROW_W'(s1_row_ff[10:1]);
            w_l = cfg.width >> 1;
            h_l = cfg.height >> 1;
         end
         2'd2: begin
            g_val = VAL_W'(val2); g_up = VAL_W'(rd2a); g_rt = VAL_W'(rd2b);
            x_l = COL_W'(s1_col_ff[9:2]);
            y_l = ROW_W'(s1_row_ff[10:2]);
            w_l = cfg.width >> 2;
            h_l = cfg.height >> 2;
         end
         default: begin
            g_val = val3; g_up = rd3a; g_rt = rd3b;
            x_l = COL_W'(s1_col_ff[9:3]);
            y_l = ROW_W'(s1_row_ff[10:3]);
            w_l = cfg.width >> 3;
            h_l = cfg.height >> 3;
         end
      endcase
   end

   assign ev_l      = s1_valid_ff && s1_ev_ff[cfg.level];
   assign x_is0     = (x_l == '0);
   assign x_is1     = (x_l == COL_W'(1));
   assign x_last    = ({1'b0, x_l} == (w_l - 1'b1));
   assign has_right = (({1'b0, x_l} + 1'b1) < w_l);
   assign grad_ev   = ev_l && (y_l >= ROW_W'(2));
   assign last      = (y_l == (h_l - 1'b1)) && x_last;

   // row ends wrap: left of column 0 is the last pixel two rows up,
   // right of the last column is column 0 of the current row
   always_comb begin
      if (has_right)  right = g_rt;
      else if (x_is0) right = g_val;
      else            right = cur_first_ff;
      if (x_is0)      left = last1_ff;
      else if (x_is1) left = first1_ff;
      else            left = hist2_ff;
   end

   assign shamt = 3'd6 - {cfg.level, 1'b0};
   assign dx = $signed({2'b00, right}) - $signed({2'b00, left});
   assign dy = $signed({2'b00, g_val}) - $signed({2'b00, g_up});
   assign gx = dx <<< shamt;
   assign gy = dy <<< shamt;

   always_ff @(posedge clock) begin
      if (wr_en[0]) prev0_ff <= val0;
      if (wr_en[1]) prev1_ff <= val1;
      if (wr_en[2]) prev2_ff <= val2;
      // edge values and the previous-row history at the selected level
      if (ev_l) begin
         hist1_ff <= g_rt;
         hist2_ff <= hist1_ff;
         if (x_is0) begin
            first1_ff    <= cur_first_ff;
            cur_first_ff <= g_val;
            last1_ff     <= lastcur_ff;
         end
         if (x_last) lastcur_ff <= g_val;
      end
      s2_gx_ff   <= gx;
      s2_gy_ff   <= gy;
      s2_last_ff <= last;
   end

   // stage 2: squared magnitude
   assign sqx    = s2_gx_ff * s2_gx_ff;
   assign sqy    = s2_gy_ff * s2_gy_ff;
   assign sq_sum = 32'(sqx) + 32'(sqy);

   always_comb begin
      push_data.grad_x        = s2_gx_ff;
      push_data.grad_y        = s2_gy_ff;
      push_data.grad_squared  = sq_sum[SQ_W-1:0];
      push_data.last_in_frame = s2_last_ff;
   end

   assign pop = rsp_chan.valid && rsp_chan.ready;

   pgm_out_fifo u_out_fifo (
      .clock(clock), .reset(reset), .push(s2_valid_ff), .push_data(push_data),
      .pop(pop), .out_valid(out_valid), .out_data(out_data), .count(fifo_count));

   assign rsp_chan.valid         = out_valid;
   assign rsp_chan.grad_x        = out_data.grad_x;
   assign rsp_chan.grad_y        = out_data.grad_y;
   assign rsp_chan.grad_squared  = out_data.grad_squared;
   assign rsp_chan.last_in_frame = out_data.last_in_frame;

   // queue never takes a result while full unless one is popped in the same cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
      else $error("result queue overflow");

   // frame start puts the pixel at the origin
   a_frame_origin: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.frame_start) |=> (s1_row_ff == '0 && s1_col_ff == '0))
      else $error("frame start did not restart position");

   // scaled gradients stay within the full-scale range
   a_grad_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_gx_ff <= 16'sd16320 && s2_gx_ff >= -16'sd16320
                       && s2_gy_ff <= 16'sd16320 && s2_gy_ff >= -16'sd16320))
      else $error("gradient out of range");

endmodule
